>>> hdl/assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
	else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/alsu_pkg.sv
package alsu_pkg;

	localparam logic OP_ISSUE = 1'b0;
	localparam logic OP_RDATA = 1'b1;

	localparam logic KIND_BUS = 1'b0;
	localparam logic KIND_REG = 1'b1;

	localparam logic [1:0] SH_LSL = 2'd0;
	localparam logic [1:0] SH_LSR = 2'd1;
	localparam logic [1:0] SH_ASR = 2'd2;
	localparam logic [1:0] SH_ROR = 2'd3;

	localparam logic [3:0]  PC_REG = 4'd15;
	localparam logic [31:0] PC_ADJ = 32'd4;

	localparam int IN_DATA_W  = 168;
	localparam int OUT_DATA_W = 104;

	typedef struct packed {
		logic        operation;
		logic [31:0] instr_word;
		logic [31:0] base_value;
		logic [31:0] offset_reg_value;
		logic [31:0] store_value;
		logic        carry_flag;
		logic [31:0] read_data;
	} item_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] bus_address;
		logic        bus_is_write;
		logic        bus_is_byte;
		logic [31:0] bus_write_data;
		logic [3:0]  reg_index;
		logic [31:0] reg_value;
		logic        last;
	} result_t;

	typedef struct packed {
		logic        load_pending;
		logic [3:0]  load_dest;
		logic [1:0]  load_addr_low;
		logic        load_byte;
		logic        wb_pending;
		logic [3:0]  wb_reg;
		logic [31:0] wb_value;
	} ls_state_t;

endpackage

>>> hdl/alsu_exec.sv
module alsu_exec (
	input  alsu_pkg::item_t     item,
	input  alsu_pkg::ls_state_t state_cur,
	output alsu_pkg::result_t   res0,
	output alsu_pkg::result_t   res1,
	output logic [1:0]          res_cnt,
	output alsu_pkg::ls_state_t state_nxt
);

	logic        pre, up, byte_acc, wbit, load, imm_n;
	logic [3:0]  rn, rd, rm;
	logic [4:0]  amt;
	logic [1:0]  typ;
	logic [31:0] rm_val, shifted, offset, indexed, addr, st_data, ld_val;
	logic [63:0] ror_wide, ld_wide;
	logic        do_wb;

	assign pre      = item.instr_word[24];
	assign up       = item.instr_word[23];
	assign byte_acc = item.instr_word[22];
	assign wbit     = item.instr_word[21];
	assign load     = item.instr_word[20];
	assign imm_n    = item.instr_word[25];
	assign rn       = item.instr_word[19:16];
	assign rd       = item.instr_word[15:12];
	assign rm       = item.instr_word[3:0];
	assign amt      = item.instr_word[11:7];
	assign typ      = item.instr_word[6:5];

	assign rm_val   = item.offset_reg_value + ((rm == alsu_pkg::PC_REG) ? alsu_pkg::PC_ADJ : 32'd0);
	assign ror_wide = {rm_val, rm_val} >> amt;

	always_comb begin
		unique case (typ)
			alsu_pkg::SH_LSL: shifted = rm_val << amt;
			alsu_pkg::SH_LSR: shifted = (amt == 5'd0) ? 32'd0 : (rm_val >> amt);
			alsu_pkg::SH_ASR: shifted = (amt == 5'd0) ? {32{rm_val[31]}} :
				32'($signed(rm_val) >>> amt);
			alsu_pkg::SH_ROR: shifted = (amt == 5'd0) ? {item.carry_flag, rm_val[31:1]} :
				ror_wide[31:0];
			default: shifted = rm_val;
		endcase
	end

	assign offset  = imm_n ? shifted : {20'd0, item.instr_word[11:0]};
	assign indexed = up ? (item.base_value + offset) : (item.base_value - offset);
	assign addr    = pre ? indexed : item.base_value;
	assign do_wb   = (!pre || wbit) && !(load && (rd == rn));

	always_comb begin
		st_data = item.store_value + ((rd == alsu_pkg::PC_REG) ? alsu_pkg::PC_ADJ : 32'd0);
		if (byte_acc) begin
			st_data = {24'd0, st_data[7:0]};
		end
	end

	assign ld_wide = {item.read_data, item.read_data} >> {state_cur.load_addr_low, 3'b000};
	assign ld_val  = state_cur.load_byte ? {24'd0, item.read_data[7:0]} : ld_wide[31:0];

	always_comb begin
		res0      = '0;
		res1      = '0;
		res_cnt   = 2'd0;
		state_nxt = state_cur;
		if (item.operation == alsu_pkg::OP_RDATA) begin
			if (state_cur.load_pending) begin
				res0.kind      = alsu_pkg::KIND_REG;
				res0.reg_index = state_cur.load_dest;
				res0.reg_value = ld_val;
				res0.last      = !state_cur.wb_pending;
				res1.kind      = alsu_pkg::KIND_REG;
				res1.reg_index = state_cur.wb_reg;
				res1.reg_value = state_cur.wb_value;
				res1.last      = 1'b1;
				res_cnt        = state_cur.wb_pending ? 2'd2 : 2'd1;
				state_nxt.load_pending = 1'b0;
				state_nxt.wb_pending   = 1'b0;
			end
		end else begin
			res0.kind        = alsu_pkg::KIND_BUS;
			res0.bus_address = addr;
			res0.bus_is_byte = byte_acc;
			res1.kind        = alsu_pkg::KIND_REG;
			res1.reg_index   = rn;
			res1.reg_value   = indexed;
			res1.last        = 1'b1;
			state_nxt.load_pending = 1'b0;
			state_nxt.wb_pending   = 1'b0;
			if (load) begin
				res0.last                = 1'b1;
				res_cnt                  = 2'd1;
				state_nxt.load_pending   = 1'b1;
				state_nxt.load_dest      = rd;
				state_nxt.load_addr_low  = addr[1:0];
				state_nxt.load_byte      = byte_acc;
				state_nxt.wb_pending     = do_wb;
				state_nxt.wb_reg         = rn;
				state_nxt.wb_value       = indexed;
			end else begin
				res0.bus_is_write   = 1'b1;
				res0.bus_write_data = st_data;
				res0.last           = !do_wb;
				res_cnt             = do_wb ? 2'd2 : 2'd1;
			end
		end
	end

endmodule

>>> hdl/arm_load_store_word_byte_unit.sv
// Path: an input transfer reaches its first result on the master side through the
// input register, then the result register.
// Throughput: one input item per cycle when each item yields at most one result and
// m_axis_tready is high; a store with writeback or a load completion with writeback
// puts two results on the output port and holds the next item until the second is accepted.
// Reset: arst_n clears the input stage, the output buffer and the pending load state.
`include "assert_macros.svh"

module arm_load_store_word_byte_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// instr_word, base_value, offset_reg_value, store_value, carry_flag, read_data, zero pad
	input  logic [167:0] s_axis_tdata,
	// operation
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// bus_address, bus_is_write, bus_is_byte, bus_write_data, reg_index, reg_value, zero pad
	output logic [103:0] m_axis_tdata,
	// kind
	output logic         m_axis_tuser,
	output logic         m_axis_tlast
);

	alsu_pkg::item_t     item_in, item_s1;
	logic                valid_s1;
	alsu_pkg::ls_state_t st_q, st_nxt;
	alsu_pkg::result_t   r0, r1, res0_q, res1_q;
	logic [1:0]          r_cnt, out_cnt_q;
	logic                out_free, adv, s_xfer, m_xfer;

	assign item_in.operation        = s_axis_tuser;
	assign item_in.instr_word       = s_axis_tdata[31:0];
	assign item_in.base_value       = s_axis_tdata[63:32];
	assign item_in.offset_reg_value = s_axis_tdata[95:64];
	assign item_in.store_value      = s_axis_tdata[127:96];
	assign item_in.carry_flag       = s_axis_tdata[128];
	assign item_in.read_data        = s_axis_tdata[160:129];

	assign m_xfer        = m_axis_tvalid && m_axis_tready;
	assign out_free      = (out_cnt_q == 2'd0) || ((out_cnt_q == 2'd1) && m_axis_tready);
	assign adv           = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || adv;
	assign s_xfer        = s_axis_tvalid && s_axis_tready;

	alsu_exec u_exec (
		.item      (item_s1),
		.state_cur (st_q),
		.res0      (r0),
		.res1      (r1),
		.res_cnt   (r_cnt),
		.state_nxt (st_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			item_s1 <= item_in;
		end
	end

	// commit pending load state as the item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= 2'd0;
		end else if (adv) begin
			out_cnt_q <= r_cnt;
		end else if (m_xfer) begin
			out_cnt_q <= out_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res0_q <= r0;
			res1_q <= r1;
		end else if (m_xfer) begin
			res0_q <= res1_q;
		end
	end

	assign m_axis_tvalid = (out_cnt_q != 2'd0);
	assign m_axis_tuser  = res0_q.kind;
	assign m_axis_tlast  = res0_q.last;
	assign m_axis_tdata  = {2'b00, res0_q.reg_value, res0_q.reg_index, res0_q.bus_write_data,
		res0_q.bus_is_byte, res0_q.bus_is_write, res0_q.bus_address};

	`ASSERT_ALWAYS(a_cnt_range, clk, arst_n, out_cnt_q != 2'd3)
	`ASSERT_IMPLIES(a_ready_when_empty, clk, arst_n, !valid_s1, s_axis_tready)
	`ASSERT_IMPLIES(a_pair_order, clk, arst_n, out_cnt_q == 2'd2,
		(res0_q.last == 1'b0) && (res1_q.kind == alsu_pkg::KIND_REG) && (res1_q.last == 1'b1))
	`ASSERT_NEXT(a_second_follows, clk, arst_n, m_xfer && (out_cnt_q == 2'd2), m_axis_tvalid)

endmodule
